### hw/rtl/grid_position_set_tracker_macros.svh
`ifndef GRID_POSITION_SET_TRACKER_MACROS_SVH
`define GRID_POSITION_SET_TRACKER_MACROS_SVH

// Concurrent check, off while reset is low.
`define GPST_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gpst assertion failed");

// Concurrent check that also runs while reset is low.
`define GPST_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gpst assertion failed");

`endif

### hw/rtl/gpst_pkg.sv
`default_nettype none

package gpst_pkg;

  localparam int GRID_WIDTH_DEF  = 8;
  localparam int GRID_HEIGHT_DEF = 8;
  localparam int VALUE_BITS_DEF  = 8;

  // Input opcodes
  typedef enum logic [1:0] {
    OPC_LOAD  = 2'd0,
    OPC_START = 2'd1,
    OPC_STEP  = 2'd2
  } opcode_e;

  // Move directions
  typedef enum logic [1:0] {
    MV_UP    = 2'd0,
    MV_RIGHT = 2'd1,
    MV_DOWN  = 2'd2,
    MV_LEFT  = 2'd3
  } move_e;

  // Classified command kinds
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_START  = 2'd1,
    CMD_STEP   = 2'd2,
    CMD_STATUS = 2'd3
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SWEEP  = 2'd1,
    ST_DRAIN  = 2'd2,
    ST_FINISH = 2'd3
  } state_e;

  // Displacement bounds of a move
  localparam logic signed [2:0] STEP_NEAR  = 3'sd1;
  localparam logic signed [2:0] STEP_FAR   = 3'sd2;
  localparam logic signed [2:0] SPREAD_LO  = -3'sd1;
  localparam logic signed [2:0] SPREAD_HI  = 3'sd1;

  typedef struct packed {
    cmd_kind_e         kind;
    logic              in_grid;
    logic signed [2:0] dx_lo;
    logic signed [2:0] dx_hi;
    logic signed [2:0] dy_lo;
    logic signed [2:0] dy_hi;
  } gpst_ctrl_t;

  // Width of a queued command: control, cell index, value, known flag, observation
  function automatic int cmd_width(input int w, input int h, input int vb);
    return $bits(gpst_ctrl_t) + $clog2(w * h) + 2 * vb + 1;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/gpst_req_if.sv
`default_nettype none

interface gpst_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [2:0] cell_x;
  logic [2:0] cell_y;
  logic [7:0] cell_value;
  logic       cell_known;
  logic [1:0] move;
  logic [7:0] observation;

  modport source (
    output valid, opcode, cell_x, cell_y, cell_value, cell_known, move, observation,
    input  ready
  );

  modport sink (
    input  valid, opcode, cell_x, cell_y, cell_value, cell_known, move, observation,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/gpst_rsp_if.sv
`default_nettype none

interface gpst_rsp_if;
  logic valid;
  logic ready;
  logic consistent;
  logic set_empty;

  modport source (
    output valid, consistent, set_empty,
    input  ready
  );

  modport sink (
    input  valid, consistent, set_empty,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/grid_position_set_tracker.sv
// Grid position set tracker.
// Input channel req carries one item per handshake: opcode, a map cell
// (cell_x, cell_y, cell_value, cell_known), a move and an observation.
// Output channel rsp returns one item per input item, in order: consistent
// and set_empty. Both channels use valid/ready.
// A load, an unused opcode and a step on an empty set need no sweep: the
// back end registers the result in its output register as it takes the item.
// A start or a step on a non-empty set sweeps every cell, one per cycle,
// through the map value memory in the address and compare stages, then
// the drain and finish states register the result; no new item is taken
// until the back end is idle again.
// An input register and a two-entry queue let up to three items wait while
// the back end sweeps, so req keeps accepting until they are full.
// Reset clears the assigned flags, the possible set and the failure flag;
// map values are undefined until loaded. No start-up pass is needed.
// When rsp stalls, the result holds in the output register and the back end
// takes no further item until it is taken.
`default_nettype none

module grid_position_set_tracker #(
  parameter int GRID_WIDTH  = gpst_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = gpst_pkg::GRID_HEIGHT_DEF,
  parameter int VALUE_BITS  = gpst_pkg::VALUE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gpst_req_if.sink   req,
  gpst_rsp_if.source rsp
);
  import gpst_pkg::*;

  localparam int CmdW = cmd_width(GRID_WIDTH, GRID_HEIGHT, VALUE_BITS);

  logic            f_valid;
  logic            f_ready;
  logic [CmdW-1:0] f_cmd;
  logic            q_valid;
  logic            q_ready;
  logic [CmdW-1:0] q_cmd;

  gpst_front #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .VALUE_BITS  (VALUE_BITS),
    .CmdW        (CmdW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  gpst_fifo #(
    .Width (CmdW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  gpst_back #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .VALUE_BITS  (VALUE_BITS),
    .CmdW        (CmdW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire

### hw/rtl/gpst_front.sv
`default_nettype none

module gpst_front #(
  parameter int GRID_WIDTH  = gpst_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = gpst_pkg::GRID_HEIGHT_DEF,
  parameter int VALUE_BITS  = gpst_pkg::VALUE_BITS_DEF,
  parameter int CmdW        = gpst_pkg::cmd_width(GRID_WIDTH, GRID_HEIGHT, VALUE_BITS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  gpst_req_if.sink        req,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output logic [CmdW-1:0] cmd_o
);
  import gpst_pkg::*;

  localparam int IdxW = $clog2(GRID_WIDTH * GRID_HEIGHT);

  gpst_ctrl_t            ctrl_d;
  logic [IdxW-1:0]       idx_d;
  logic [VALUE_BITS-1:0] val_d;
  logic [VALUE_BITS-1:0] obs_d;
  logic                  vld_q;
  logic [CmdW-1:0]       cmd_q;
  logic                  accept;

  assign req.ready = !vld_q || cmd_ready_i;
  assign accept    = req.valid && req.ready;

  always_comb begin
    ctrl_d.in_grid = (int'(req.cell_x) < GRID_WIDTH) && (int'(req.cell_y) < GRID_HEIGHT);
    case (req.opcode)
      OPC_LOAD:  ctrl_d.kind = CMD_LOAD;
      OPC_START: ctrl_d.kind = CMD_START;
      OPC_STEP:  ctrl_d.kind = CMD_STEP;
      default:   ctrl_d.kind = CMD_STATUS;
    endcase
    case (req.move)
      MV_UP: begin
        ctrl_d.dx_lo = SPREAD_LO;  ctrl_d.dx_hi = SPREAD_HI;
        ctrl_d.dy_lo = STEP_NEAR;  ctrl_d.dy_hi = STEP_FAR;
      end
      MV_RIGHT: begin
        ctrl_d.dx_lo = STEP_NEAR;  ctrl_d.dx_hi = STEP_FAR;
        ctrl_d.dy_lo = SPREAD_LO;  ctrl_d.dy_hi = SPREAD_HI;
      end
      MV_DOWN: begin
        ctrl_d.dx_lo = SPREAD_LO;  ctrl_d.dx_hi = SPREAD_HI;
        ctrl_d.dy_lo = -STEP_FAR;  ctrl_d.dy_hi = -STEP_NEAR;
      end
      default: begin
        ctrl_d.dx_lo = -STEP_FAR;  ctrl_d.dx_hi = -STEP_NEAR;
        ctrl_d.dy_lo = SPREAD_LO;  ctrl_d.dy_hi = SPREAD_HI;
      end
    endcase
  end

  assign idx_d = IdxW'(int'(req.cell_x) * GRID_HEIGHT + int'(req.cell_y));
  assign val_d = VALUE_BITS'(req.cell_value);
  assign obs_d = VALUE_BITS'(req.observation);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (cmd_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= {ctrl_d, idx_d, val_d, req.cell_known, obs_d};
    end
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

`default_nettype wire

### hw/rtl/gpst_fifo.sv
`default_nettype none

module gpst_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  logic [Width-1:0] buf_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push;
  logic             pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gpst_back.sv
`default_nettype none

module gpst_back #(
  parameter int GRID_WIDTH  = gpst_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = gpst_pkg::GRID_HEIGHT_DEF,
  parameter int VALUE_BITS  = gpst_pkg::VALUE_BITS_DEF,
  parameter int CmdW        = gpst_pkg::cmd_width(GRID_WIDTH, GRID_HEIGHT, VALUE_BITS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  logic [CmdW-1:0] cmd_i,
  gpst_rsp_if.source      rsp
);
  import gpst_pkg::*;

  localparam int NCells = GRID_WIDTH * GRID_HEIGHT;
  localparam int IdxW   = $clog2(NCells);
  localparam int XW     = $clog2(GRID_WIDTH);
  localparam int YW     = $clog2(GRID_HEIGHT);
  localparam int SW     = ((XW > YW) ? XW : YW) + 3;
  localparam logic signed [SW-1:0] XMax = SW'(GRID_WIDTH - 1);
  localparam logic signed [SW-1:0] YMax = SW'(GRID_HEIGHT - 1);

  // Incoming command fields
  gpst_ctrl_t            cmd_ctrl;
  logic [IdxW-1:0]       cmd_idx;
  logic [VALUE_BITS-1:0] cmd_val;
  logic                  cmd_known;
  logic [VALUE_BITS-1:0] cmd_obs;

  state_e                state_q, state_d;
  gpst_ctrl_t            ctrl_q;
  logic [VALUE_BITS-1:0] obs_q;

  // Sweep address stage
  logic [XW-1:0]         x_q;
  logic [YW-1:0]         y_q;
  logic [IdxW-1:0]       idx_q;
  logic                  last;

  // Sweep compare stage
  logic                  b_vld_q;
  logic [XW-1:0]         b_x_q;
  logic [YW-1:0]         b_y_q;
  logic [IdxW-1:0]       b_idx_q;
  logic                  b_reach_q;
  logic [VALUE_BITS-1:0] rdata_q;
  logic                  hit;

  logic [VALUE_BITS-1:0] map_val_q [NCells];
  logic [NCells-1:0]     known_q;
  logic [GRID_WIDTH-1:0][GRID_HEIGHT-1:0] poss_q;
  logic [GRID_WIDTH-1:0][GRID_HEIGHT-1:0] nxt_q;
  logic                  any_q;
  logic                  empty_q;
  logic                  failed_q;

  logic                  out_vld_q;
  logic                  out_cons_q;
  logic                  out_empty_q;

  logic                  out_free;
  logic                  is_sweep;
  logic                  cmd_pop;
  logic                  sweep_en;
  logic                  finish_en;

  // Predecessor window around the current target cell
  logic signed [SW-1:0]  tx, ty, dxl, dxh, dyl, dyh;
  logic signed [SW-1:0]  sx [5];
  logic signed [SW-1:0]  sy [5];
  logic [4:0]            x_ok;
  logic [4:0]            y_ok;
  logic                  reach;

  function automatic logic signed [SW-1:0] clampv(input logic signed [SW-1:0] v,
                                                  input logic signed [SW-1:0] hi);
    if (v[SW-1]) begin
      return '0;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  assign {cmd_ctrl, cmd_idx, cmd_val, cmd_known, cmd_obs} = cmd_i;

  assign out_free = !out_vld_q || rsp.ready;
  assign is_sweep = (cmd_ctrl.kind == CMD_START) || ((cmd_ctrl.kind == CMD_STEP) && !empty_q);
  assign last     = idx_q == IdxW'(NCells - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free && is_sweep) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready_o = 1'b0;
    sweep_en    = 1'b0;
    finish_en   = 1'b0;
    case (state_q)
      ST_IDLE:   cmd_ready_o = out_free;
      ST_SWEEP:  sweep_en    = 1'b1;
      ST_FINISH: finish_en   = 1'b1;
      default: ;
    endcase
  end

  assign cmd_pop = cmd_valid_i && cmd_ready_o;

  // A target is reached if some possible source within two cells maps onto it
  always_comb begin
    tx  = $signed(SW'(x_q));
    ty  = $signed(SW'(y_q));
    dxl = SW'(ctrl_q.dx_lo);
    dxh = SW'(ctrl_q.dx_hi);
    dyl = SW'(ctrl_q.dy_lo);
    dyh = SW'(ctrl_q.dy_hi);
    for (int k = 0; k < 5; k++) begin
      sx[k]   = tx + SW'(k - 2);
      sy[k]   = ty + SW'(k - 2);
      x_ok[k] = !sx[k][SW-1] && (sx[k] <= XMax) &&
                (clampv(sx[k] + dxl, XMax) <= tx) && (tx <= clampv(sx[k] + dxh, XMax));
      y_ok[k] = !sy[k][SW-1] && (sy[k] <= YMax) &&
                (clampv(sy[k] + dyl, YMax) <= ty) && (ty <= clampv(sy[k] + dyh, YMax));
    end
    reach = 1'b0;
    for (int kx = 0; kx < 5; kx++) begin
      for (int ky = 0; ky < 5; ky++) begin
        if (x_ok[kx] && y_ok[ky] && poss_q[sx[kx][XW-1:0]][sy[ky][YW-1:0]]) begin
          reach = 1'b1;
        end
      end
    end
  end

  assign hit = b_reach_q && (!known_q[b_idx_q] || (rdata_q == obs_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      idx_q       <= '0;
      b_vld_q     <= 1'b0;
      known_q     <= '0;
      poss_q      <= '0;
      any_q       <= 1'b0;
      empty_q     <= 1'b1;
      failed_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      out_cons_q  <= 1'b1;
      out_empty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      b_vld_q <= sweep_en;

      if (cmd_pop) begin
        x_q   <= '0;
        y_q   <= '0;
        idx_q <= '0;
        any_q <= 1'b0;
        if (cmd_ctrl.kind == CMD_LOAD && cmd_ctrl.in_grid) begin
          known_q[cmd_idx] <= cmd_known;
        end
      end else if (sweep_en) begin
        idx_q <= idx_q + 1'b1;
        if (y_q == YW'(GRID_HEIGHT - 1)) begin
          y_q <= '0;
          x_q <= x_q + 1'b1;
        end else begin
          y_q <= y_q + 1'b1;
        end
      end

      if (b_vld_q) begin
        any_q <= any_q | hit;
      end

      // Step on an empty set fails and leaves the set empty
      if (cmd_pop && cmd_ctrl.kind == CMD_STEP && empty_q) begin
        failed_q <= 1'b1;
      end

      if (finish_en) begin
        poss_q  <= nxt_q;
        empty_q <= !any_q;
        if (ctrl_q.kind == CMD_START) begin
          failed_q <= 1'b0;
        end
      end

      if (finish_en) begin
        out_vld_q   <= 1'b1;
        out_cons_q  <= (ctrl_q.kind == CMD_START) || !failed_q;
        out_empty_q <= !any_q;
      end else if (cmd_pop && !is_sweep) begin
        out_vld_q   <= 1'b1;
        out_cons_q  <= !failed_q && (cmd_ctrl.kind != CMD_STEP);
        out_empty_q <= empty_q;
      end else if (rsp.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop) begin
      ctrl_q <= cmd_ctrl;
      obs_q  <= cmd_obs;
    end
    if (cmd_pop && cmd_ctrl.kind == CMD_LOAD && cmd_ctrl.in_grid) begin
      map_val_q[cmd_idx] <= cmd_val;
    end
    if (sweep_en) begin
      rdata_q   <= map_val_q[idx_q];
      b_x_q     <= x_q;
      b_y_q     <= y_q;
      b_idx_q   <= idx_q;
      b_reach_q <= (ctrl_q.kind == CMD_START) || reach;
    end
    if (b_vld_q) begin
      nxt_q[b_x_q][b_y_q] <= hit;
    end
  end

  assign rsp.valid      = out_vld_q;
  assign rsp.consistent = out_cons_q;
  assign rsp.set_empty  = out_empty_q;

endmodule

`default_nettype wire

### hw/rtl/gpst_checker.sv
`default_nettype none

`include "grid_position_set_tracker_macros.svh"

module gpst_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic rsp_consistent_i,
  input logic rsp_set_empty_i
);

  localparam logic [2:0] MaxPending = 3'd5;

  logic [2:0] pend_q;
  logic       acc;
  logic       del;

  assign acc = req_valid_i && req_ready_i;
  assign del = rsp_valid_i && rsp_ready_i;

  // Count items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (acc && !del) begin
      pend_q <= pend_q + 1'b1;
    end else if (del && !acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  `GPST_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_consistent_i) && $stable(rsp_set_empty_i))
  `GPST_ASSERT(a_fail_empty, clk_i, rst_ni, rsp_valid_i && !rsp_consistent_i |-> rsp_set_empty_i)
  `GPST_ASSERT(a_no_orphan, clk_i, rst_ni, rsp_valid_i |-> pend_q != 3'd0)
  `GPST_ASSERT(a_pend_bound, clk_i, rst_ni, pend_q <= MaxPending)
  `GPST_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !rsp_valid_i)

endmodule

bind grid_position_set_tracker gpst_checker u_gpst_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req.valid),
  .req_ready_i      (req.ready),
  .rsp_valid_i      (rsp.valid),
  .rsp_ready_i      (rsp.ready),
  .rsp_consistent_i (rsp.consistent),
  .rsp_set_empty_i  (rsp.set_empty)
);

`default_nettype wire

### verif/tb_grid_position_set_tracker.sv
`default_nettype none

module tb_grid_position_set_tracker;
  import gpst_pkg::*;

  localparam int GRID_W = GRID_WIDTH_DEF;
  localparam int GRID_H = GRID_HEIGHT_DEF;
  localparam int GRID_CELLS = GRID_W * GRID_H;
  localparam int RANDOM_ITEMS = 1550;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] OPC_NONE = 2'd3;

  typedef struct packed {
    logic consistent;
    logic set_empty;
  } status_t;

  // Tracks the map, the possible set and the failure flag; queues one
  // status per accepted item.
  class pos_set_scoreboard;
    logic [7:0] map_val [GRID_CELLS];
    bit map_known [GRID_CELLS];
    bit possible [GRID_CELLS];
    bit failed;
    status_t status_due [$];
    int errors, checked, starts, full_map_starts, steps, empty_steps, empty_results;

    function new();
      foreach (map_val[i]) begin
        map_val[i] = '0;
        map_known[i] = 0;
        possible[i] = 0;
      end
      failed = 0;
    endfunction

    function bit cell_ok(int idx, logic [7:0] obs);
      return !map_known[idx] || map_val[idx] == obs;
    endfunction

    function bit set_is_empty();
      foreach (possible[i])
        if (possible[i]) return 0;
      return 1;
    endfunction

    function int clamp_coord(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    function void note_item(logic [1:0] op, logic [2:0] cx, logic [2:0] cy,
                            logic [7:0] cval, logic ckn, logic [1:0] mv,
                            logic [7:0] obs);
      bit nxt [GRID_CELLS];
      bit all_known;
      int dxlo, dxhi, dylo, dyhi, idx;
      status_t st;
      case (op)
        OPC_LOAD: begin
          if (cx < GRID_W && cy < GRID_H) begin
            idx = cx * GRID_H + cy;
            map_val[idx] = cval;
            map_known[idx] = ckn;
          end
        end
        OPC_START: begin
          all_known = 1;
          foreach (possible[i]) begin
            possible[i] = cell_ok(i, obs);
            all_known &= map_known[i];
          end
          failed = 0;
          starts++;
          if (all_known) full_map_starts++;
        end
        OPC_STEP: begin
          steps++;
          if (set_is_empty()) begin
            failed = 1;
            empty_steps++;
          end else begin
            case (move_e'(mv))
              MV_UP:    begin dxlo = -1; dxhi = 1;  dylo = 1;  dyhi = 2;  end
              MV_RIGHT: begin dxlo = 1;  dxhi = 2;  dylo = -1; dyhi = 1;  end
              MV_DOWN:  begin dxlo = -1; dxhi = 1;  dylo = -2; dyhi = -1; end
              default:  begin dxlo = -2; dxhi = -1; dylo = -1; dyhi = 1;  end
            endcase
            foreach (nxt[i]) nxt[i] = 0;
            for (int x = 0; x < GRID_W; x++) begin
              for (int y = 0; y < GRID_H; y++) begin
                if (!possible[x * GRID_H + y]) continue;
                for (int dx = dxlo; dx <= dxhi; dx++) begin
                  for (int dy = dylo; dy <= dyhi; dy++) begin
                    idx = clamp_coord(x + dx, GRID_W - 1) * GRID_H
                        + clamp_coord(y + dy, GRID_H - 1);
                    if (cell_ok(idx, obs)) nxt[idx] = 1;
                  end
                end
              end
            end
            possible = nxt;
          end
        end
        default: ;
      endcase
      st.consistent = !failed;
      st.set_empty = set_is_empty();
      status_due.push_back(st);
    endfunction

    function void check_status(logic consistent, logic set_empty);
      status_t want;
      if (status_due.size() == 0) begin
        $error("result with none pending: consistent=%0b set_empty=%0b",
               consistent, set_empty);
        errors++;
        return;
      end
      want = status_due.pop_front();
      checked++;
      if (want.set_empty) empty_results++;
      if (consistent !== want.consistent) begin
        $error("consistent: expected %0b, actual %0b", want.consistent, consistent);
        errors++;
      end
      if (set_empty !== want.set_empty) begin
        $error("set_empty: expected %0b, actual %0b", want.set_empty, set_empty);
        errors++;
      end
    endfunction

    function int pending();
      return status_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  gpst_req_if req_ch ();
  gpst_rsp_if rsp_ch ();

  grid_position_set_tracker u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  pos_set_scoreboard sb = new();

  bit hold_rsp_req;
  int items_sent;
  int burst_left;
  bit gapless;
  int known_pct;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  initial begin
    #8000000;
    $display("tb_grid_position_set_tracker: FAIL");
    $finish;
  end

  // Receiver: switch between stall patterns, and hold off for a long
  // stretch when the sender asks for it.
  initial begin : rsp_side
    int mode, mode_left, hold_left;
    int unsigned cyc;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    cyc = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (rst_ni && rsp_ch.valid && rsp_ch.ready)
        sb.check_status(rsp_ch.consistent, rsp_ch.set_empty);
      if (hold_rsp_req) begin
        hold_rsp_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(30, 250);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          2: rsp_ch.ready <= ($urandom_range(0, 4) != 0);
          default: rsp_ch.ready <= (cyc % 7 >= 3);
        endcase
      end
    end
  end

  // Drop valid for a random gap at the end of each burst not marked gapless.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = gapless ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
      gapless = ($urandom_range(0, 3) == 0);
    end
  endtask

  task automatic send_item(logic [1:0] op, logic [2:0] cx, logic [2:0] cy,
                           logic [7:0] cval, logic ckn, logic [1:0] mv,
                           logic [7:0] obs);
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.cell_x <= cx;
    req_ch.cell_y <= cy;
    req_ch.cell_value <= cval;
    req_ch.cell_known <= ckn;
    req_ch.move <= mv;
    req_ch.observation <= obs;
    do @(posedge clk_i); while (!req_ch.ready);
    sb.note_item(op, cx, cy, cval, ckn, mv, obs);
    items_sent++;
    pace();
  endtask

  function automatic logic [7:0] pick_value();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 3));
  endfunction

  task automatic load_cell(int x, int y, logic [7:0] v, logic kn);
    send_item(OPC_LOAD, 3'(x), 3'(y), v, kn, 2'($urandom), 8'($urandom));
  endtask

  task automatic start_seq(logic [7:0] obs);
    send_item(OPC_START, 3'($urandom), 3'($urandom), 8'($urandom), 1'($urandom),
              2'($urandom), obs);
  endtask

  task automatic step(move_e mv, logic [7:0] obs);
    send_item(OPC_STEP, 3'($urandom), 3'($urandom), 8'($urandom), 1'($urandom),
              mv, obs);
  endtask

  task automatic poll_status();
    send_item(OPC_NONE, 3'($urandom), 3'($urandom), 8'($urandom), 1'($urandom),
              2'($urandom), 8'($urandom));
  endtask

  task automatic random_load();
    load_cell($urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1),
              pick_value(), $urandom_range(0, 99) < known_pct);
  endtask

  // Hold the sender until every pending result is back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Stall the receiver and keep offering items until the input backs up.
  task automatic fill_block();
    hold_rsp_req = 1;
    burst_left = 16;
    start_seq(pick_value());
    step(move_e'($urandom_range(0, 3)), pick_value());
    for (int i = 0; i < 10; i++) begin
      if (i % 3 == 0) poll_status();
      else random_load();
    end
    drain();
  endtask

  initial begin : stimulus
    int first, next_drain, kind, n;
    bit mid_fill_done;
    rst_ni = 1'b0;
    hold_rsp_req = 0;
    items_sent = 0;
    burst_left = 0;
    gapless = 0;
    known_pct = 70;
    mid_fill_done = 0;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OPC_LOAD;
    req_ch.cell_x <= '0;
    req_ch.cell_y <= '0;
    req_ch.cell_value <= '0;
    req_ch.cell_known <= 1'b0;
    req_ch.move <= MV_UP;
    req_ch.observation <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Write every cell before any sweep reads the map; all assigned.
    for (int x = 0; x < GRID_W; x++)
      for (int y = 0; y < GRID_H; y++)
        load_cell(x, y, (x == 3 && y == 4) ? 8'hff : 8'($urandom_range(0, 3)), 1'b1);

    // Directed: status and steps on an empty set, fully assigned map,
    // clamping at the corners, restart after failure.
    poll_status();
    step(MV_UP, 8'h00);
    step(MV_RIGHT, 8'h00);
    poll_status();
    start_seq(8'hff);
    step(MV_UP, 8'hff);
    step(MV_DOWN, 8'hff);
    start_seq(8'd200);
    load_cell(0, 0, 8'h00, 1'b0);
    load_cell(7, 7, 8'hff, 1'b1);
    start_seq(8'd200);
    step(MV_DOWN, 8'd200);
    step(MV_LEFT, 8'd200);
    start_seq(8'hff);
    step(MV_RIGHT, 8'hff);
    step(MV_UP, 8'hff);
    step(MV_LEFT, 8'h00);
    load_cell(7, 0, 8'h00, 1'b0);
    start_seq(8'h00);
    step(MV_DOWN, 8'h00);
    step(MV_UP, 8'h03);
    poll_status();
    drain();
    fill_block();

    first = items_sent;
    next_drain = $urandom_range(150, 350);
    while (items_sent - first < RANDOM_ITEMS) begin
      if (items_sent - first >= next_drain) begin
        drain();
        next_drain += $urandom_range(150, 350);
      end
      if (!mid_fill_done && items_sent - first >= RANDOM_ITEMS / 2) begin
        mid_fill_done = 1;
        fill_block();
      end
      kind = $urandom_range(0, 99);
      if (kind < 4) begin
        // New map regime; fully unassigned and fully assigned ones rewrite every cell.
        case ($urandom_range(0, 3))
          0: known_pct = 0;
          1: known_pct = 30;
          2: known_pct = 70;
          default: known_pct = 100;
        endcase
        if (known_pct == 0 || known_pct == 100) begin
          for (int x = 0; x < GRID_W; x++)
            for (int y = 0; y < GRID_H; y++)
              load_cell(x, y, pick_value(), known_pct == 100);
        end else begin
          n = $urandom_range(8, 24);
          repeat (n) random_load();
        end
      end else if (kind < 85) begin
        n = $urandom_range(0, 2);
        repeat (n) random_load();
        start_seq(pick_value());
        n = $urandom_range(1, 14);
        repeat (n) begin
          case ($urandom_range(0, 19))
            0: random_load();
            1: poll_status();
            default: ;
          endcase
          step(move_e'($urandom_range(0, 3)), pick_value());
        end
      end else begin
        n = $urandom_range(1, 6);
        repeat (n)
          send_item(2'($urandom), 3'($urandom), 3'($urandom), 8'($urandom),
                    1'($urandom), 2'($urandom), 8'($urandom));
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    $display("checked %0d results over %0d items: %0d starts (%0d on a fully assigned map)",
             sb.checked, items_sent, sb.starts, sb.full_map_starts);
    $display("%0d steps, %0d of them on an empty set; %0d results reported an empty set",
             sb.steps, sb.empty_steps, sb.empty_results);
    if (sb.errors == 0)
      $display("tb_grid_position_set_tracker: PASS");
    else
      $display("tb_grid_position_set_tracker: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+hw/rtl
hw/rtl/gpst_pkg.sv
hw/rtl/gpst_req_if.sv
hw/rtl/gpst_rsp_if.sv
hw/rtl/gpst_front.sv
hw/rtl/gpst_fifo.sv
hw/rtl/gpst_back.sv
hw/rtl/grid_position_set_tracker.sv
hw/rtl/gpst_checker.sv
verif/tb_grid_position_set_tracker.sv
